// ===== rtl/wsfd_pkg.sv =====
// wsfd_pkg: shared types and constants of the WebSocket frame decoder.
// Used by wsfd_parser, wsfd_out_buf and websocket_frame_decoder.
`timescale 1ns / 1ps

package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CLS_DATA  = 2'd0,
        CLS_PING  = 2'd1,
        CLS_CLOSE = 2'd2,
        CLS_DROP  = 2'd3
    } frame_cls_t;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_CLOSED   = 2'd2;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic [1:0] frame_kind;
        logic       last_of_frame;
        logic [1:0] status;
    } result_t;

endpackage

// ===== rtl/wsfd_parser.sv =====
// wsfd_parser: frame header parser, length check and payload unmasking.
// One byte per beat; state registers feed a single combinational step.
// Depends on wsfd_pkg.
`timescale 1ns / 1ps

module wsfd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 byte_en,
    input  logic [7:0]           in_byte,
    output logic                 res_valid,
    output wsfd_pkg::result_t    res
);

    wsfd_pkg::phase_t     phase_reg, phase_next;
    wsfd_pkg::frame_cls_t cls_reg, cls_next;
    logic                 mask_reg, mask_next;
    logic [63:0]          len_reg, len_next;
    logic [31:0]          rem_reg, rem_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [31:0]          key_reg, key_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 stopped_reg, stopped_next;
    logic [31:0]          max_reg;

    logic                 do_ld, do_bp, do_end, last_byte;
    logic [7:0]           key_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= wsfd_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            max_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= wsfd_pkg::PH_HDR0;
            cls_reg     <= wsfd_pkg::CLS_DROP;
            mask_reg    <= 1'b0;
            len_reg     <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            key_reg     <= '0;
            idx_reg     <= '0;
            stopped_reg <= 1'b0;
        end else if (byte_en) begin
            phase_reg   <= phase_next;
            cls_reg     <= cls_next;
            mask_reg    <= mask_next;
            len_reg     <= len_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            key_reg     <= key_next;
            idx_reg     <= idx_next;
            stopped_reg <= stopped_next;
        end
    end

    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        cls_next     = cls_reg;
        mask_next    = mask_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        stopped_next = stopped_reg;
        res_valid    = 1'b0;
        res          = '0;
        do_ld        = 1'b0;
        do_bp        = 1'b0;
        do_end       = 1'b0;
        last_byte    = (rem_reg == 32'd1);

        if (!stopped_reg) begin
            unique case (phase_reg)
                wsfd_pkg::PH_HDR0: begin
                    unique case (in_byte[3:0])
                        wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY: cls_next = wsfd_pkg::CLS_DATA;
                        wsfd_pkg::OP_PING:  cls_next = wsfd_pkg::CLS_PING;
                        wsfd_pkg::OP_CLOSE: cls_next = wsfd_pkg::CLS_CLOSE;
                        default:            cls_next = wsfd_pkg::CLS_DROP;
                    endcase
                    phase_next = wsfd_pkg::PH_HDR1;
                end
                wsfd_pkg::PH_HDR1: begin
                    mask_next = in_byte[7];
                    if (in_byte[6:0] == wsfd_pkg::LEN_EXT16 ||
                        in_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
                        len_next   = '0;
                        cnt_next   = (in_byte[6:0] == wsfd_pkg::LEN_EXT16) ?
                                     wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                        phase_next = wsfd_pkg::PH_EXTLEN;
                    end else begin
                        len_next = {57'd0, in_byte[6:0]};
                        do_ld    = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXTLEN: begin
                    len_next = {len_reg[55:0], in_byte};
                    cnt_next = cnt_reg - 4'd1;
                    do_ld    = (cnt_reg == 4'd1);
                end
                wsfd_pkg::PH_MASK: begin
                    key_next = {key_reg[23:0], in_byte};
                    cnt_next = cnt_reg - 4'd1;
                    do_bp    = (cnt_reg == 4'd1);
                end
                wsfd_pkg::PH_PAYLOAD: begin
                    rem_next = rem_reg - 32'd1;
                    idx_next = idx_reg + 2'd1;
                    if (last_byte) begin
                        phase_next = wsfd_pkg::PH_HDR0;
                    end
                    case (cls_reg)
                        wsfd_pkg::CLS_CLOSE: begin
                            if (last_byte) begin
                                stopped_next      = 1'b1;
                                res_valid         = 1'b1;
                                res.frame_kind    = wsfd_pkg::KIND_CLOSE;
                                res.last_of_frame = 1'b1;
                                res.status        = wsfd_pkg::ST_CLOSED;
                            end
                        end
                        wsfd_pkg::CLS_DROP: ;
                        default: begin
                            res_valid         = 1'b1;
                            res.payload_byte  = mask_reg ? (in_byte ^ key_byte) : in_byte;
                            res.has_byte      = 1'b1;
                            res.frame_kind    = cls_reg;
                            res.last_of_frame = last_byte;
                            res.status        = wsfd_pkg::ST_OK;
                        end
                    endcase
                end
                default: phase_next = wsfd_pkg::PH_HDR0;
            endcase
        end

        // length complete: limit check before any masking key
        if (do_ld) begin
            if (len_next[63:32] != 32'd0 || len_next[31:0] > max_reg) begin
                stopped_next = 1'b1;
                phase_next   = wsfd_pkg::PH_HDR0;
                res_valid    = 1'b1;
                res.status   = wsfd_pkg::ST_OVERSIZE;
            end else if (mask_next) begin
                phase_next = wsfd_pkg::PH_MASK;
                cnt_next   = wsfd_pkg::KEY_BYTES;
                key_next   = '0;
            end else begin
                do_bp = 1'b1;
            end
        end

        if (do_bp) begin
            idx_next = '0;
            if (len_next == 64'd0) begin
                do_end = 1'b1;
            end else begin
                phase_next = wsfd_pkg::PH_PAYLOAD;
                rem_next   = len_next[31:0];
            end
        end

        // empty frame: marker straight from the header
        if (do_end) begin
            phase_next = wsfd_pkg::PH_HDR0;
            case (cls_reg)
                wsfd_pkg::CLS_CLOSE: begin
                    stopped_next      = 1'b1;
                    res_valid         = 1'b1;
                    res.frame_kind    = wsfd_pkg::KIND_CLOSE;
                    res.last_of_frame = 1'b1;
                    res.status        = wsfd_pkg::ST_CLOSED;
                end
                wsfd_pkg::CLS_DROP: ;
                default: begin
                    res_valid         = 1'b1;
                    res.frame_kind    = cls_reg;
                    res.last_of_frame = 1'b1;
                    res.status        = wsfd_pkg::ST_OK;
                end
            endcase
        end
    end

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

    a_quiet_when_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> !res_valid)
        else $error("result produced after stream stopped");

    a_payload_len_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wsfd_pkg::PH_PAYLOAD) |-> (rem_reg != 32'd0))
        else $error("payload phase with no bytes remaining");

    a_stop_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_en && !stopped_reg && stopped_next) |->
        (res_valid && res.status != wsfd_pkg::ST_OK))
        else $error("stream stopped without an error or close result");

endmodule

// ===== rtl/wsfd_out_buf.sv =====
// wsfd_out_buf: two-entry result register with skid slot.
// Depends on wsfd_pkg for the result struct.
`timescale 1ns / 1ps

module wsfd_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  wsfd_pkg::result_t    push_data,
    output logic                 has_room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wsfd_pkg::result_t    out_data
);

    wsfd_pkg::result_t head_reg, tail_reg;
    logic              head_v_reg, tail_v_reg;
    logic              pop;

    assign pop       = head_v_reg && out_ready;
    assign has_room  = !tail_v_reg;
    assign out_valid = head_v_reg;
    assign out_data  = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
        end else if (pop) begin
            if (tail_v_reg) begin
                tail_v_reg <= push;
            end else begin
                head_v_reg <= push;
            end
        end else if (!head_v_reg) begin
            head_v_reg <= push;
        end else if (push) begin
            tail_v_reg <= 1'b1;
        end
    end

    // payload slots: advance tail into head on pop, park new beat where free
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (tail_v_reg) begin
                head_reg <= tail_reg;
                tail_reg <= push_data;
            end else begin
                head_reg <= push_data;
            end
        end else if (!head_v_reg) begin
            head_reg <= push_data;
        end else if (push) begin
            tail_reg <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_v_reg |-> !push)
        else $error("push into full result buffer");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_v_reg |-> head_v_reg)
        else $error("skid slot occupied with empty head");

    a_skid_promotes: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_v_reg && pop) |=> (head_v_reg && head_reg == $past(tail_reg)))
        else $error("skid beat lost on pop");

endmodule

// ===== rtl/websocket_frame_decoder.sv =====
// websocket_frame_decoder: top level of the WebSocket frame decoder.
// Instantiates wsfd_parser and wsfd_out_buf; depends on wsfd_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (s_valid/s_ready/s_in_byte) carries the stream after the
//   opening handshake, one byte per beat. Result channel (m_valid/m_ready
//   and the m_ payload ports) gives at most one result per input byte:
//   an unmasked payload byte, an empty-frame marker, a close marker or an
//   oversize error.
//   cfg_wr_en/cfg_wr_data write max_payload (reset 65536);
//   write it only while the block is idle.
//   Each result is registered in the result buffer before it shows on m_.
//   Throughput: one byte per cycle while the result buffer has room; the
//   parser state update is a single registered step and the two-entry result
//   buffer keeps s_ready high while one result waits on the output.
//   Stall: when m_ready stays low, the buffer fills and s_ready drops
//   after two pending results; no result is dropped.
//   Reset: synchronous, aresetn low clears the parser to the first header
//   byte, empties the buffer and restores max_payload. After a close or
//   oversize result the stream is ignored (bytes still accepted) until reset.

module websocket_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_has_byte,
    output logic [1:0]  m_frame_kind,
    output logic        m_last_of_frame,
    output logic [1:0]  m_status
);

    logic              byte_en;
    logic              res_valid;
    logic              has_room;
    wsfd_pkg::result_t res;
    wsfd_pkg::result_t out_data;

    assign byte_en = s_valid && s_ready;
    assign s_ready = has_room;

    wsfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_en     (byte_en),
        .in_byte     (s_in_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    wsfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (byte_en && res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_payload_byte  = out_data.payload_byte;
    assign m_has_byte      = out_data.has_byte;
    assign m_frame_kind    = out_data.frame_kind;
    assign m_last_of_frame = out_data.last_of_frame;
    assign m_status        = out_data.status;

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for websocket_frame_decoder (frame parse, unmask, stop).
// Depends on rtl/wsfd_pkg.sv and rtl/websocket_frame_decoder.sv; a built-in
// frame parser predicts every result beat from the accepted byte stream.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 8;

    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    localparam logic [3:0] OP_CONT     = 4'h0;
    localparam logic [3:0] OP_PONG     = 4'hA;
    localparam logic [3:0] OP_RESERVED = 4'hF;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte   = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_payload_byte;
    logic        m_has_byte;
    logic [1:0]  m_frame_kind;
    logic        m_last_of_frame;
    logic [1:0]  m_status;

    websocket_frame_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_has_byte      (m_has_byte),
        .m_frame_kind    (m_frame_kind),
        .m_last_of_frame (m_last_of_frame),
        .m_status        (m_status)
    );

    always #4 aclk = ~aclk;

    logic [7:0]         stream_q[$];
    wsfd_pkg::result_t  expected_results[$];
    int                 queued_bytes = 0;
    int                 fail_count   = 0;
    int                 cycle_count  = 0;
    int                 gap_left     = 0;
    int                 rx_stall     = 0;
    int                 hold_req     = 0;
    int                 hold_seen    = 0;

    // shadow parser state
    wsfd_pkg::phase_t parse_phase = wsfd_pkg::PH_HDR0;
    logic [3:0]  cur_opcode  = 4'd0;
    logic        key_on      = 1'b0;
    logic [63:0] frame_len   = 64'd0;
    logic [3:0]  hdr_left    = 4'd0;
    logic [31:0] mask_word   = 32'd0;
    logic [63:0] byte_idx    = 64'd0;
    logic        halted      = 1'b0;
    logic [31:0] max_len     = wsfd_pkg::MAX_PAYLOAD_RESET;

    wire tx_calm = (cycle_count[9:8] == 2'b11);
    wire rx_calm = (cycle_count[10:9] == 2'b01);

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic wsfd_pkg::frame_cls_t class_of(logic [3:0] op);
        case (op) inside
            wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY: return wsfd_pkg::CLS_DATA;
            wsfd_pkg::OP_PING:                      return wsfd_pkg::CLS_PING;
            wsfd_pkg::OP_CLOSE:                     return wsfd_pkg::CLS_CLOSE;
            default:                                return wsfd_pkg::CLS_DROP;
        endcase
    endfunction

    function automatic logic [1:0] kind_of(wsfd_pkg::frame_cls_t c);
        return (c == wsfd_pkg::CLS_PING) ? wsfd_pkg::KIND_PING : wsfd_pkg::KIND_DATA;
    endfunction

    function automatic void push_result(logic [7:0] b, logic has, logic [1:0] kind,
                                        logic last, logic [1:0] st);
        wsfd_pkg::result_t r;
        r.payload_byte  = b;
        r.has_byte      = has;
        r.frame_kind    = kind;
        r.last_of_frame = last;
        r.status        = st;
        expected_results.push_back(r);
    endfunction

    function automatic void close_frame();
        wsfd_pkg::frame_cls_t c;
        c = class_of(cur_opcode);
        parse_phase = wsfd_pkg::PH_HDR0;
        if (c == wsfd_pkg::CLS_CLOSE) begin
            halted = 1'b1;
            push_result(8'd0, 1'b0, wsfd_pkg::KIND_CLOSE, 1'b1, wsfd_pkg::ST_CLOSED);
        end else if (c != wsfd_pkg::CLS_DROP) begin
            push_result(8'd0, 1'b0, kind_of(c), 1'b1, wsfd_pkg::ST_OK);
        end
    endfunction

    function automatic void start_payload();
        byte_idx = 64'd0;
        if (frame_len == 64'd0) close_frame();
        else parse_phase = wsfd_pkg::PH_PAYLOAD;
    endfunction

    function automatic void length_complete();
        if (frame_len > {32'd0, max_len}) begin
            halted = 1'b1;
            parse_phase = wsfd_pkg::PH_HDR0;
            push_result(8'd0, 1'b0, wsfd_pkg::KIND_DATA, 1'b0, wsfd_pkg::ST_OVERSIZE);
        end else if (key_on) begin
            parse_phase = wsfd_pkg::PH_MASK;
            hdr_left = wsfd_pkg::KEY_BYTES;
            mask_word = 32'd0;
        end else begin
            start_payload();
        end
    endfunction

    // advance the shadow parser by one accepted byte
    function automatic void decode_byte(logic [7:0] b);
        wsfd_pkg::frame_cls_t c;
        logic [7:0] v;
        logic       last;
        if (halted) return;
        case (parse_phase)
            wsfd_pkg::PH_HDR0: begin
                cur_opcode = b[3:0];
                parse_phase = wsfd_pkg::PH_HDR1;
            end
            wsfd_pkg::PH_HDR1: begin
                key_on = b[7];
                frame_len = 64'd0;
                if (b[6:0] == wsfd_pkg::LEN_EXT16 || b[6:0] == wsfd_pkg::LEN_EXT64) begin
                    hdr_left = (b[6:0] == wsfd_pkg::LEN_EXT16) ?
                               wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                    parse_phase = wsfd_pkg::PH_EXTLEN;
                end else begin
                    frame_len = {57'd0, b[6:0]};
                    length_complete();
                end
            end
            wsfd_pkg::PH_EXTLEN: begin
                frame_len = {frame_len[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0) length_complete();
            end
            wsfd_pkg::PH_MASK: begin
                mask_word = {mask_word[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0) start_payload();
            end
            wsfd_pkg::PH_PAYLOAD: begin
                c = class_of(cur_opcode);
                v = b;
                if (key_on) v = v ^ mask_word[8 * (3 - byte_idx[1:0]) +: 8];
                byte_idx = byte_idx + 64'd1;
                last = (byte_idx >= frame_len);
                if (last) parse_phase = wsfd_pkg::PH_HDR0;
                if (c == wsfd_pkg::CLS_CLOSE) begin
                    if (last) begin
                        halted = 1'b1;
                        push_result(8'd0, 1'b0, wsfd_pkg::KIND_CLOSE, 1'b1,
                                    wsfd_pkg::ST_CLOSED);
                    end
                end else if (c != wsfd_pkg::CLS_DROP) begin
                    push_result(v, 1'b1, kind_of(c), last, wsfd_pkg::ST_OK);
                end
            end
            default: parse_phase = wsfd_pkg::PH_HDR0;
        endcase
    endfunction

    function automatic void put(logic [7:0] b);
        stream_q.push_back(b);
        queued_bytes++;
    endfunction

    function automatic void queue_header(logic [3:0] op, logic masked, logic [63:0] len,
                                         int form, logic [31:0] key);
        logic [3:0] flags;
        flags = 4'($urandom_range(0, 15));
        put({flags, op});
        case (form)
            FORM_SHORT: put({masked, len[6:0]});
            FORM_EXT16: begin
                put({masked, wsfd_pkg::LEN_EXT16});
                put(len[15:8]);
                put(len[7:0]);
            end
            default: begin
                put({masked, wsfd_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--) put(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--) put(key[8 * i +: 8]);
    endfunction

    function automatic void queue_frame(logic [3:0] op, logic masked, logic [63:0] len,
                                        int form);
        queue_header(op, masked, len, form, $urandom);
        for (longint i = 0; i < longint'(len); i++) put(8'($urandom_range(0, 255)));
    endfunction

    // random frames, lengths held within the current limit
    function automatic void queue_random_frames(int budget);
        int         start;
        int         pick;
        logic [3:0] op;
        logic [63:0] len;
        int         form;
        start = queued_bytes;
        while (queued_bytes - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) op = wsfd_pkg::OP_TEXT;
            else if (pick < 70) op = wsfd_pkg::OP_BINARY;
            else if (pick < 85) op = wsfd_pkg::OP_PING;
            else begin
                op = 4'($urandom_range(0, 15));
                while (class_of(op) != wsfd_pkg::CLS_DROP) op = 4'($urandom_range(0, 15));
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) len = 64'd0;
            else if (pick < 75) len = 64'($urandom_range(1, 12));
            else if (pick < 95) len = 64'($urandom_range(13, 125));
            else len = 64'($urandom_range(126, 300));
            if (len > {32'd0, max_len}) len = {32'd0, max_len};
            pick = $urandom_range(0, 99);
            if (len > 64'd125) form = int'($urandom_range(FORM_EXT16, FORM_EXT64));
            else if (pick < 70) form = FORM_SHORT;
            else if (pick < 85) form = FORM_EXT16;
            else form = FORM_EXT64;
            queue_frame(op, 1'($urandom_range(0, 1)), len, form);
        end
    endfunction

    // sender
    always @(posedge aclk) begin
        bit busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_in_byte <= 8'd0;
            gap_left <= 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (stream_q.size() > 0) begin
                    s_in_byte <= stream_q.pop_front();
                    busy = 1'b1;
                    if (!tx_calm && $urandom_range(0, 3) == 0) gap_left <= pick_gap();
                end
            end
            s_valid <= busy;
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            rx_stall <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            rx_stall <= pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        wsfd_pkg::result_t r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: byte 0x%0h kind %0d status %0d",
                       m_payload_byte, m_frame_kind, m_status);
                fail_count++;
            end else begin
                r = expected_results.pop_front();
                check_field("payload_byte", r.payload_byte, m_payload_byte);
                check_field("has_byte", 8'(r.has_byte), 8'(m_has_byte));
                check_field("frame_kind", 8'(r.frame_kind), 8'(m_frame_kind));
                check_field("last_of_frame", 8'(r.last_of_frame), 8'(m_last_of_frame));
                check_field("status", 8'(r.status), 8'(m_status));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold new bytes until every queued beat is accepted and every result is back
    task automatic drain();
        while (stream_q.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(logic [31:0] value);
        drain();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        max_len = value;
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] tail_limit;
        logic [63:0] big_len;
        int          tail_case;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames under the reset limit
        queue_frame(wsfd_pkg::OP_TEXT, 1'b0, 64'd0, FORM_SHORT);
        queue_frame(wsfd_pkg::OP_PING, 1'b1, 64'd0, FORM_SHORT);
        queue_header(wsfd_pkg::OP_TEXT, 1'b1, 64'd4, FORM_SHORT, 32'hFFFF_FFFF);
        put(8'h00); put(8'hFF); put(8'h00); put(8'hFF);
        queue_header(wsfd_pkg::OP_BINARY, 1'b0, 64'd2, FORM_EXT16, 32'd0);
        put(8'hFF); put(8'h00);
        queue_frame(wsfd_pkg::OP_PING, 1'b1, 64'd3, FORM_EXT64);
        queue_frame(OP_PONG, 1'b1, 64'd2, FORM_SHORT);
        queue_frame(OP_CONT, 1'b0, 64'd1, FORM_EXT16);
        queue_frame(OP_RESERVED, 1'b0, 64'd0, FORM_SHORT);
        queue_frame(wsfd_pkg::OP_BINARY, 1'b1, 64'd0, FORM_EXT64);

        queue_frame(wsfd_pkg::OP_BINARY, 1'b0, 64'd125, FORM_SHORT);
        queue_random_frames(200);
        drain();

        // stall the receiver while the sender keeps offering
        @(posedge aclk);
        hold_req <= hold_req + 1;
        @(negedge aclk);
        queue_random_frames(120);
        queue_random_frames(150);

        write_limit(32'd0);
        queue_random_frames(60);

        write_limit(32'hFFFF_FFFF);
        queue_frame(wsfd_pkg::OP_TEXT, 1'b1, 64'd130, FORM_EXT64);
        queue_random_frames(200);

        write_limit(32'd17);
        queue_frame(wsfd_pkg::OP_BINARY, 1'b1, 64'd17, FORM_EXT16);
        queue_random_frames(180);

        write_limit($urandom_range(1, 200));
        queue_random_frames(250);

        // finish the stream with a close or an oversize frame
        tail_limit = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(20, 120);
        write_limit(tail_limit);
        queue_random_frames(120);
        tail_case = int'($urandom_range(0, 2));
        if (tail_case == 0) begin
            queue_frame(wsfd_pkg::OP_CLOSE, 1'($urandom_range(0, 1)), 64'd0, FORM_SHORT);
        end else if (tail_case == 1) begin
            queue_frame(wsfd_pkg::OP_CLOSE, 1'b1, 64'($urandom_range(1, 9)),
                        int'($urandom_range(0, 2)));
        end else begin
            big_len = {32'd0, tail_limit} + 64'd1;
            queue_header($urandom_range(0, 1) ? wsfd_pkg::OP_BINARY : OP_PONG, 1'b1,
                         big_len, (big_len > 64'd125) ? FORM_EXT64 : FORM_SHORT, $urandom);
        end
        // the block ignores everything from here on
        for (int i = 0; i < 20; i++) put(8'($urandom_range(0, 255)));

        drain();
        if (fail_count == 0 && expected_results.size() == 0 && !m_valid)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_buf.sv
rtl/websocket_frame_decoder.sv
tb/tb.sv
